>>> sv/bad_pkg.sv
package bad_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic [8:0] sample_count;
    } out_item_t;

    localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_STEP_X        = 3'd2;
    localparam logic [2:0] REG_STEP_Y        = 3'd3;
    localparam logic [2:0] REG_HAS_ALPHA     = 3'd4;
    localparam logic [2:0] REG_ALPHA_GAIN    = 3'd5;

    typedef struct packed {
        logic start_load;
        logic start_setup;
        logic start_sum;
        logic start_div;
        logic load_out;
    } bad_cmd_t;

    typedef struct packed {
        logic setup_done;
        logic sum_done;
        logic div_done;
    } bad_sts_t;

endpackage

>>> sv/bad_ctrl.sv
module bad_ctrl
    import bad_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic     in_mode,
    output logic     out_valid,
    input  logic     out_stall,
    output bad_cmd_t cmd,
    input  bad_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        cmd              = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.start_load = 1'b1;
                    if (in_mode)
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                cmd.start_setup = 1'b1;
                if (sts.setup_done)
                begin
                    state_next = ST_SUM;
                    cmd.start_sum = 1'b1;
                end
            end
            ST_SUM:
            begin
                if (sts.sum_done)
                begin
                    state_next = ST_DIV;
                    cmd.start_div = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (out_valid_reg && !out_stall && !cmd.load_out)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/bad_dp.sv
module bad_dp
    import bad_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RATIO  = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  logic [8:0]  cfg_width,
    input  logic [8:0]  cfg_height,
    input  logic [12:0] cfg_step_x,
    input  logic [12:0] cfg_step_y,
    input  logic        cfg_has_alpha,
    input  logic [8:0]  cfg_gain,
    input  bad_cmd_t  cmd,
    output bad_sts_t  sts,
    input  logic      out_load,
    output out_item_t out_item
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int SMAX = MAX_RATIO * 256;
    localparam int DW = 32;
    localparam int QW = 8;

    logic [31:0] mem [0:(1 << AW) - 1];
    logic [31:0] rd_reg;
    logic [AW-1:0] rd_addr;
    logic        rd_en;

    logic [7:0]  px_reg, py_reg;
    logic [1:0]  setup_reg;
    logic [XW:0] cx_reg, xlo_reg, xhi_reg, x_reg;
    logic [YW:0] cy_reg, ylo_reg, yhi_reg, y_reg;
    logic [12:0] sx_reg, sy_reg;
    logic [8:0]  gain_reg;
    logic [XW:0] w_eff;
    logic [YW:0] h_eff;
    logic [12:0] sx_eff, sy_eff;
    logic [20:0] prod_x, prod_y;

    logic        sum_run_reg, first_reg, rd_pend_reg, rd_last_reg;
    logic [19:0] sum_r_reg, sum_g_reg, sum_b_reg, sum_a_reg;
    logic [8:0]  count_reg;

    logic [31:0] a_prod_reg;
    logic [2:0]  ch_reg;
    logic [5:0]  bit_reg;
    logic        div_run_reg, div_done_reg;
    logic [DW-1:0] rem_reg, dsr_reg, num_reg;
    logic [QW-1:0] q_reg;
    logic [7:0]  res_r_reg, res_g_reg, res_b_reg, res_a_reg;
    logic [DW:0] rem_sh;
    logic [7:0]  alpha_pix;
    logic        sum_done_reg;

    assign w_eff  = (cfg_width == 9'd0) ? (XW+1)'(1) :
                    ((32'(cfg_width) > MAX_WIDTH) ? (XW+1)'(MAX_WIDTH) : (XW+1)'(cfg_width));
    assign h_eff  = (cfg_height == 9'd0) ? (YW+1)'(1) :
                    ((32'(cfg_height) > MAX_HEIGHT) ? (YW+1)'(MAX_HEIGHT) : (YW+1)'(cfg_height));
    assign sx_eff = (cfg_step_x == 13'd0) ? 13'd1 :
                    ((32'(cfg_step_x) > SMAX) ? 13'(SMAX) : cfg_step_x);
    assign sy_eff = (cfg_step_y == 13'd0) ? 13'd1 :
                    ((32'(cfg_step_y) > SMAX) ? 13'(SMAX) : cfg_step_y);
    assign prod_x = 21'(px_reg) * 21'(sx_reg);
    assign prod_y = 21'(py_reg) * 21'(sy_reg);

    function automatic logic [12:0] lo_of(input logic [12:0] c, input logic [12:0] s);
        logic [21:0] c9;
        begin
            c9 = 22'(c) << 9;
            lo_of = (c9 >= 22'(s)) ? 13'((c9 - 22'(s)) >> 9) : 13'd0;
        end
    endfunction

    function automatic logic [12:0] hi_of(input logic [12:0] c, input logic [12:0] s);
        logic [22:0] c9;
        begin
            c9 = (23'(c) << 9) + 23'(s) + 23'd511;
            hi_of = (c9 >> 9) > 23'(8191) ? 13'h1FFF : 13'(c9 >> 9);
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.start_load)
        begin
            px_reg <= in_item.pos_x;
            py_reg <= in_item.pos_y;
            sx_reg <= sx_eff;
            sy_reg <= sy_eff;
            gain_reg <= (cfg_gain > 9'd256) ? 9'd256 : cfg_gain;
        end
        if (cmd.start_load && !in_item.mode && 32'(in_item.pos_x) < MAX_WIDTH
            && 32'(in_item.pos_y) < MAX_HEIGHT)
        begin
            mem[AW'({YW'(in_item.pos_y), XW'(in_item.pos_x)})] <=
                {in_item.in_alpha, in_item.in_blue, in_item.in_green, in_item.in_red};
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_reg <= '0;
        end
        else if (cmd.start_setup)
        begin
            setup_reg <= setup_reg + 2'd1;
        end
        else
        begin
            setup_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_setup && setup_reg == 2'd0)
        begin
            cx_reg <= (21'(prod_x >> 8) > 21'(w_eff - 1'b1)) ? w_eff - 1'b1
                                                            : (XW+1)'(prod_x >> 8);
            cy_reg <= (21'(prod_y >> 8) > 21'(h_eff - 1'b1)) ? h_eff - 1'b1
                                                            : (YW+1)'(prod_y >> 8);
        end
        if (cmd.start_setup && setup_reg == 2'd1)
        begin
            xhi_reg <= (hi_of(13'(cx_reg), sx_reg) > 13'(w_eff)) ? w_eff
                       : (XW+1)'(hi_of(13'(cx_reg), sx_reg));
            yhi_reg <= (hi_of(13'(cy_reg), sy_reg) > 13'(h_eff)) ? h_eff
                       : (YW+1)'(hi_of(13'(cy_reg), sy_reg));
            xlo_reg <= (XW+1)'(lo_of(13'(cx_reg), sx_reg));
            ylo_reg <= (YW+1)'(lo_of(13'(cy_reg), sy_reg));
        end
        if (cmd.start_setup && setup_reg == 2'd2)
        begin
            if (xlo_reg > xhi_reg) xlo_reg <= xhi_reg;
            if (ylo_reg > yhi_reg) ylo_reg <= yhi_reg;
        end
    end

    assign sts.setup_done = cmd.start_setup && setup_reg == 2'd2;

    assign rd_en   = cmd.start_sum || sum_run_reg;
    assign rd_addr = cmd.start_sum ? AW'({YW'(cy_reg), XW'(cx_reg)})
                                   : AW'({YW'(y_reg), XW'(x_reg)});
    assign alpha_pix = cfg_has_alpha ? rd_reg[31:24] : 8'd255;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_run_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            rd_last_reg <= 1'b0;
            first_reg   <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= rd_en;
            first_reg   <= cmd.start_sum;
            if (cmd.start_sum)
            begin
                sum_run_reg <= (xlo_reg < xhi_reg) && (ylo_reg < yhi_reg);
                rd_last_reg <= !((xlo_reg < xhi_reg) && (ylo_reg < yhi_reg));
            end
            else if (rd_en)
            begin
                rd_last_reg <= (x_reg + 1'b1 == xhi_reg) && (y_reg + 1'b1 == yhi_reg);
                if (x_reg + 1'b1 == xhi_reg && y_reg + 1'b1 == yhi_reg)
                begin
                    sum_run_reg <= 1'b0;
                end
            end
            else
            begin
                rd_last_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_sum)
        begin
            x_reg <= xlo_reg;
            y_reg <= ylo_reg;
        end
        else if (rd_en)
        begin
            if (x_reg + 1'b1 == xhi_reg)
            begin
                x_reg <= xlo_reg;
                y_reg <= y_reg + 1'b1;
            end
            else
            begin
                x_reg <= x_reg + 1'b1;
            end
        end
        if (rd_pend_reg)
        begin
            if (first_reg)
            begin
                sum_r_reg <= 20'(rd_reg[7:0]);
                sum_g_reg <= 20'(rd_reg[15:8]);
                sum_b_reg <= 20'(rd_reg[23:16]);
                sum_a_reg <= 20'(alpha_pix);
                count_reg <= 9'd1;
            end
            else
            begin
                sum_r_reg <= sum_r_reg + 20'(rd_reg[7:0]);
                sum_g_reg <= sum_g_reg + 20'(rd_reg[15:8]);
                sum_b_reg <= sum_b_reg + 20'(rd_reg[23:16]);
                sum_a_reg <= sum_a_reg + 20'(alpha_pix);
                count_reg <= count_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_done_reg <= 1'b0;
        end
        else
        begin
            sum_done_reg <= rd_pend_reg && rd_last_reg;
        end
    end
    assign sts.sum_done = sum_done_reg;

    assign rem_sh = {rem_reg, num_reg[DW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_run_reg  <= 1'b0;
            div_done_reg <= 1'b0;
            ch_reg       <= '0;
            bit_reg      <= '0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            if (cmd.start_div)
            begin
                div_run_reg <= 1'b1;
                ch_reg      <= 3'd0;
                bit_reg     <= 6'(DW - 1);
            end
            else if (div_run_reg)
            begin
                if (bit_reg == 6'd0)
                begin
                    if (ch_reg == 3'd3)
                    begin
                        div_run_reg  <= 1'b0;
                        div_done_reg <= 1'b1;
                    end
                    ch_reg  <= ch_reg + 3'd1;
                    bit_reg <= 6'(DW - 1);
                end
                else
                begin
                    bit_reg <= bit_reg - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            a_prod_reg <= 32'(sum_a_reg) * 32'(gain_reg);
            rem_reg    <= '0;
            num_reg    <= 32'(sum_r_reg);
            dsr_reg    <= 32'(count_reg);
            q_reg      <= '0;
        end
        else if (div_run_reg)
        begin
            if (bit_reg == 6'd0)
            begin
                case (ch_reg)
                    3'd0: res_r_reg <= 8'({q_reg[QW-2:0], rem_sh >= 33'(dsr_reg)});
                    3'd1: res_g_reg <= 8'({q_reg[QW-2:0], rem_sh >= 33'(dsr_reg)});
                    3'd2: res_b_reg <= 8'({q_reg[QW-2:0], rem_sh >= 33'(dsr_reg)});
                    default: res_a_reg <= 8'({q_reg[QW-2:0], rem_sh >= 33'(dsr_reg)});
                endcase
                rem_reg <= '0;
                q_reg   <= '0;
                case (ch_reg)
                    3'd0:
                    begin
                        num_reg <= 32'(sum_g_reg);
                        dsr_reg <= 32'(count_reg);
                    end
                    3'd1:
                    begin
                        num_reg <= 32'(sum_b_reg);
                        dsr_reg <= 32'(count_reg);
                    end
                    default:
                    begin
                        num_reg <= a_prod_reg;
                        dsr_reg <= {15'd0, count_reg, 8'd0};
                    end
                endcase
            end
            else
            begin
                num_reg <= num_reg << 1;
                if (rem_sh >= 33'(dsr_reg))
                begin
                    rem_reg <= DW'(rem_sh - 33'(dsr_reg));
                    q_reg   <= {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= DW'(rem_sh);
                    q_reg   <= {q_reg[QW-2:0], 1'b0};
                end
            end
        end
        if (out_load)
        begin
            out_item.out_red      <= res_r_reg;
            out_item.out_green    <= res_g_reg;
            out_item.out_blue     <= res_b_reg;
            out_item.out_alpha    <= res_a_reg;
            out_item.sample_count <= count_reg;
        end
    end

    assign sts.div_done = div_done_reg;

endmodule

>>> sv/box_average_image_downscaler_core.sv
// Channel | Handshake                   | Payload
// in      | in_valid / in_stall         | in_item (in_item_t)
// out     | out_valid / out_stall       | out_item (out_item_t)
// cfg     | APB psel/penable/pwrite     | paddr, pwdata, prdata
// A store item is written to the frame store on its accept. A compute item raises
// out_valid after the setup steps, the centre read and one frame-store read per
// sample of its window of N samples (up to 256), then four 32-step restoring
// divides. rst_n clears control, not the store. Input stalls while a compute item
// is at work; a finished result waits until the previous one is taken.
module box_average_image_downscaler_core
    import bad_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RATIO  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [8:0]  width_reg, height_reg, gain_reg;
    logic [12:0] step_x_reg, step_y_reg;
    logic        has_alpha_reg;
    bad_cmd_t    cmd;
    bad_sts_t    sts;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 9'd256;
            height_reg    <= 9'd256;
            step_x_reg    <= 13'd256;
            step_y_reg    <= 13'd256;
            has_alpha_reg <= 1'b1;
            gain_reg      <= 9'd256;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SOURCE_WIDTH:  width_reg     <= pwdata[8:0];
                REG_SOURCE_HEIGHT: height_reg    <= pwdata[8:0];
                REG_STEP_X:        step_x_reg    <= pwdata[12:0];
                REG_STEP_Y:        step_y_reg    <= pwdata[12:0];
                REG_HAS_ALPHA:     has_alpha_reg <= pwdata[0];
                REG_ALPHA_GAIN:    gain_reg      <= pwdata[8:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SOURCE_WIDTH:  prdata = {23'd0, width_reg};
            REG_SOURCE_HEIGHT: prdata = {23'd0, height_reg};
            REG_STEP_X:        prdata = {19'd0, step_x_reg};
            REG_STEP_Y:        prdata = {19'd0, step_y_reg};
            REG_HAS_ALPHA:     prdata = {31'd0, has_alpha_reg};
            REG_ALPHA_GAIN:    prdata = {23'd0, gain_reg};
            default:           prdata = '0;
        endcase
    end

    bad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_mode   (in_item.mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    bad_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RATIO  (MAX_RATIO)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_item       (in_item),
        .cfg_width     (width_reg),
        .cfg_height    (height_reg),
        .cfg_step_x    (step_x_reg),
        .cfg_step_y    (step_y_reg),
        .cfg_has_alpha (has_alpha_reg),
        .cfg_gain      (gain_reg),
        .cmd           (cmd),
        .sts           (sts),
        .out_load      (cmd.load_out),
        .out_item      (out_item)
    );

endmodule
